// File: rtl/core/mszd_pkg.sv
package mszd_pkg;

  localparam int MARKER_LEN = 8;
  localparam int MAX_FRAME_BYTES_DEF = 2097152;
  localparam int LIMIT_W = 22;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 22'd2097152;

  // Marker bytes, position 0 is the oldest byte in the window.
  localparam logic [7:0] MARK_JPG [MARKER_LEN] = '{
    8'h4A, 8'h50, 8'h47, 8'h44, 8'h41, 8'h54, 8'h41, 8'h00
  };
  localparam logic [7:0] MARK_CAM [MARKER_LEN] = '{
    8'h43, 8'h41, 8'h4D, 8'h44, 8'h41, 8'h54, 8'h41, 8'h00
  };

  typedef enum logic [0:0] {
    KIND_JPG = 1'b0,
    KIND_CAM = 1'b1
  } frame_kind_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_LEN  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  // Per-cell compare flags for the window contents after a shift.
  typedef struct packed {
    logic jpg;
    logic cam;
  } win_hit_t;

  typedef struct packed {
    logic       size_error;
    logic       empty_frame;
    logic       last_byte;
    logic       first_byte;
    logic       frame_kind;
    logic [7:0] data_byte;
  } out_item_t;

endpackage

// File: rtl/core/mszd_cell.sv
module mszd_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              clear,
  input  logic [7:0]        byte_in,
  input  logic              vld_in,
  output logic [7:0]        byte_out,
  output logic              vld_out,
  output mszd_pkg::win_hit_t hit
);
  import mszd_pkg::*;

  logic [7:0] data;
  logic       vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (clear) begin
      vld <= 1'b0;
    end else if (shift) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= byte_in;
    end
  end

  // Compare what this cell will hold once the current byte is shifted in.
  assign hit.jpg = vld_in && (byte_in == MARK_JPG[IDX]);
  assign hit.cam = vld_in && (byte_in == MARK_CAM[IDX]);

  assign byte_out = data;
  assign vld_out  = vld;

endmodule

// File: rtl/core/marker_sized_frame_deframer.sv
// Each body, empty or error result is registered before it appears on m_tvalid.
// Throughput: one byte per cycle while s_tready is high; the marker compare is spread over a row of eight window
// cells and the length check is one 32-bit compare, so no input beat waits on another.
// s_tready drops only while both the output register and the skid register hold results.
// Reset (rst, synchronous) returns to the marker hunt with an empty window and sets
// frame_limit to 2097152.
module marker_sized_frame_deframer #(
  parameter int MAX_FRAME_BYTES = mszd_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] in_byte
  input  logic                        s_tuser,   // [0] restart
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [7:0] data_byte
  output logic                        m_tlast,
  output logic [3:0]                  m_tuser,   // [0] frame_kind [1] first_byte
                                                 // [2] empty_frame [3] size_error
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mszd_pkg::LIMIT_W-1:0] cfg_data
);
  import mszd_pkg::*;

  localparam int REM_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [31:0] MAX_LIM = 32'(MAX_FRAME_BYTES);

  logic [LIMIT_W-1:0] frame_limit;
  phase_t             phase;
  logic [31:0]        length_shift;
  logic [1:0]         length_seen;
  logic [REM_W-1:0]   body_remaining;
  logic               body_started;
  logic               current_kind;

  logic      accept, restart, start_hunt, shift;
  logic [7:0] in_byte;
  logic [31:0] length_full, lim;
  logic      res_v;
  out_item_t res;
  out_item_t out_r, skid_r;
  logic      out_v, skid_v;

  logic [7:0] cell_byte [MARKER_LEN+1];
  logic       cell_vld  [MARKER_LEN+1];
  win_hit_t   cell_hit  [MARKER_LEN];
  logic [MARKER_LEN-1:0] hit_jpg, hit_cam;
  logic       match_jpg, match_cam;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_v;
  assign accept    = s_tvalid && s_tready;
  assign restart   = s_tuser;
  assign in_byte   = s_tdata;
  assign shift     = accept && !restart && (phase != PH_LEN) && (phase != PH_BODY);

  // The newest byte enters at the top cell and moves toward cell 0.
  assign cell_byte[MARKER_LEN] = in_byte;
  assign cell_vld[MARKER_LEN]  = 1'b1;

  for (genvar i = 0; i < MARKER_LEN; i++) begin : g_win
    mszd_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .clear    (start_hunt),
      .byte_in  (cell_byte[i+1]),
      .vld_in   (cell_vld[i+1]),
      .byte_out (cell_byte[i]),
      .vld_out  (cell_vld[i]),
      .hit      (cell_hit[i])
    );
    assign hit_jpg[i] = cell_hit[i].jpg;
    assign hit_cam[i] = cell_hit[i].cam;
  end

  assign match_jpg = &hit_jpg;
  assign match_cam = &hit_cam;

  assign length_full = {in_byte, length_shift[31:8]};
  assign lim = (32'(frame_limit) > MAX_LIM) ? MAX_LIM : 32'(frame_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frame_limit <= cfg_data;
    end
  end

  always_comb begin
    res_v      = 1'b0;
    start_hunt = 1'b0;
    res        = '0;
    res.frame_kind = current_kind;
    if (accept) begin
      if (restart) begin
        start_hunt = 1'b1;
      end else begin
        unique case (phase)
          PH_LEN: begin
            if (length_seen == 2'd3) begin
              if (length_full == 32'd0 || length_full[31]) begin
                res_v = 1'b1;
                res.first_byte  = 1'b1;
                res.last_byte   = 1'b1;
                res.empty_frame = 1'b1;
                start_hunt = 1'b1;
              end else if (length_full > lim) begin
                res_v = 1'b1;
                res.first_byte = 1'b1;
                res.last_byte  = 1'b1;
                res.size_error = 1'b1;
                start_hunt = 1'b1;
              end
            end
          end
          PH_BODY: begin
            res_v = 1'b1;
            res.data_byte  = in_byte;
            res.first_byte = !body_started;
            res.last_byte  = (body_remaining <= REM_W'(1));
            start_hunt = res.last_byte;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      length_shift   <= '0;
      length_seen    <= '0;
      body_remaining <= '0;
      body_started   <= 1'b0;
      current_kind   <= KIND_JPG;
    end else if (start_hunt) begin
      phase          <= PH_HUNT;
      length_shift   <= '0;
      length_seen    <= '0;
      body_remaining <= '0;
      body_started   <= 1'b0;
    end else if (accept) begin
      unique case (phase)
        PH_LEN: begin
          length_shift <= length_full;
          if (length_seen != 2'd3) begin
            length_seen <= length_seen + 2'd1;
          end else begin
            // Length is known to be in range here, so its low bits hold it all.
            body_remaining <= length_full[REM_W-1:0];
            body_started   <= 1'b0;
            length_seen    <= '0;
            phase          <= PH_BODY;
          end
        end
        PH_BODY: begin
          body_started   <= 1'b1;
          body_remaining <= body_remaining - REM_W'(1);
        end
        default: begin
          phase <= PH_HUNT;
          if (match_jpg || match_cam) begin
            current_kind <= match_cam ? KIND_CAM : KIND_JPG;
            phase        <= PH_LEN;
            length_shift <= '0;
            length_seen  <= '0;
          end
        end
      endcase
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_tready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= res_v;
      end
    end else if (res_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_tready) begin
      if (skid_v) begin
        out_r <= skid_r;
      end else if (res_v) begin
        out_r <= res;
      end
    end else if (res_v) begin
      skid_r <= res;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_r.data_byte;
  assign m_tlast  = out_r.last_byte;
  assign m_tuser  = {out_r.size_error, out_r.empty_frame, out_r.first_byte, out_r.frame_kind};

endmodule
